// File: hdl/sixteen_segment_char_serializer_unit_defines.svh
// assertion macros shared by the serializer modules
// no dependencies; expects clk and rst_n in the including module
`ifndef SIXTEEN_SEGMENT_CHAR_SERIALIZER_UNIT_DEFINES_SVH
`define SIXTEEN_SEGMENT_CHAR_SERIALIZER_UNIT_DEFINES_SVH

// check on every clock edge outside reset
`define SSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every clock edge, reset included
`define SSC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/ssc_pkg.sv
// types, constants and font tables for the sixteen-segment serializer
// no dependencies
package ssc_pkg;

    localparam int SEG_W = 16;
    localparam int CNT_W = $clog2(SEG_W);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(SEG_W - 1);

    typedef logic [SEG_W-1:0] seg_t;

    // command codes
    typedef enum logic [1:0] {
        CMD_ASCII  = 2'd0,
        CMD_RAW    = 2'd1,
        CMD_SYMBOL = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    // symbol character codes, digit and letter bounds and case offset
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_HYPHEN = 8'h2D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam int NUM_SYMBOLS = 8;

    localparam seg_t DIGIT_FONT [10] = '{
        16'hFF09, 16'h3000, 16'hEEC0, 16'hFCC0, 16'h31C0,
        16'hCD84, 16'hDFC0, 16'hF000, 16'hFFC0, 16'hFDC0
    };

    localparam seg_t LETTER_FONT [26] = '{
        16'hF3C0, 16'hFC52, 16'hCF00, 16'hFC12, 16'hCFC0, 16'hC380, 16'hDF40, 16'h33C0,
        16'hCC12, 16'h3E00, 16'h038C, 16'h0F00, 16'h3328, 16'h3324, 16'hFF00, 16'hE3C0,
        16'hFF04, 16'hE3C4, 16'hDDC0, 16'hC012, 16'h3F00, 16'h0F09, 16'h3305, 16'h002D,
        16'h002A, 16'hCC09
    };

    // blank, underbar, hyphen, backslash, bar, slash, plus, star
    localparam seg_t SYMBOL_FONT [NUM_SYMBOLS] = '{
        16'h0000, 16'h0C00, 16'h00C0, 16'h0024, 16'h0012, 16'h0009, 16'h00D2, 16'h00FF
    };

    // what the holding register hands to the shifter on a load
    typedef struct packed {
        seg_t pattern;
        logic display;
    } load_t;

endpackage

// File: hdl/ssc_encoder.sv
// font lookup: turns a command and payload into a segment pattern
// depends on ssc_pkg
module ssc_encoder
    import ssc_pkg::*;
(
    input  logic [1:0]       cmd,
    input  logic [SEG_W-1:0] payload,
    output seg_t             pattern,
    output logic             emit
);

    logic [7:0] code;
    logic [7:0] folded;
    logic [7:0] letter_idx;
    logic [7:0] digit_idx;
    seg_t       char_pat;

    // fold lower case and look the character up
    always_comb
    begin
        code = payload[7:0];
        if (code >= CH_LOWER_A && code <= CH_LOWER_Z)
        begin
            folded = code - CASE_OFFSET;
        end
        else
        begin
            folded = code;
        end
        letter_idx = folded - CH_UPPER_A;
        digit_idx  = folded - CH_ZERO;
        if (folded >= CH_UPPER_A && folded <= CH_UPPER_Z)
        begin
            char_pat = LETTER_FONT[letter_idx[4:0]];
        end
        else if (folded >= CH_ZERO && folded <= CH_NINE)
        begin
            char_pat = DIGIT_FONT[digit_idx[3:0]];
        end
        else
        begin
            unique case (folded)
                CH_SPACE:  char_pat = SYMBOL_FONT[0];
                CH_UNDER:  char_pat = SYMBOL_FONT[1];
                CH_HYPHEN: char_pat = SYMBOL_FONT[2];
                CH_BSLASH: char_pat = SYMBOL_FONT[3];
                CH_BAR:    char_pat = SYMBOL_FONT[4];
                CH_SLASH:  char_pat = SYMBOL_FONT[5];
                CH_PLUS:   char_pat = SYMBOL_FONT[6];
                CH_STAR:   char_pat = SYMBOL_FONT[7];
                default:   char_pat = '0;
            endcase
        end
    end

    // pick the pattern source by command
    always_comb
    begin
        unique case (cmd_t'(cmd))
            CMD_ASCII:
            begin
                pattern = char_pat;
                emit    = 1'b1;
            end
            CMD_RAW:
            begin
                pattern = payload;
                emit    = 1'b1;
            end
            CMD_SYMBOL:
            begin
                if (payload < SEG_W'(NUM_SYMBOLS))
                begin
                    pattern = SYMBOL_FONT[payload[2:0]];
                end
                else
                begin
                    pattern = '0;
                end
                emit = 1'b1;
            end
            default:
            begin
                pattern = '0;
                emit    = 1'b0;
            end
        endcase
    end

endmodule

// File: hdl/ssc_shifter.sv
// serial shift-out of one pattern, lsb first, with the latch mark on the last bit
// depends on ssc_pkg and the assertion macro header
`include "sixteen_segment_char_serializer_unit_defines.svh"

module ssc_shifter
    import ssc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  load,
    input  load_t load_data,
    output logic  ready,
    output logic  bit_valid,
    input  logic  bit_stall,
    output logic  target_display,
    output logic  serial_bit,
    output logic  latch_now
);

    seg_t             pattern_reg, pattern_next;
    logic             display_reg, display_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             take;

    assign take  = busy_reg && !bit_stall;
    assign ready = !busy_reg || (take && cnt_reg == LAST_BIT);

    // next shift state: load, advance on a taken bit, or go idle after the last
    always_comb
    begin
        pattern_next = pattern_reg;
        display_next = display_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        if (load)
        begin
            pattern_next = load_data.pattern;
            display_next = load_data.display;
            cnt_next     = '0;
            busy_next    = 1'b1;
        end
        else if (take)
        begin
            if (cnt_reg == LAST_BIT)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pattern_next = pattern_reg >> 1;
                cnt_next     = cnt_reg + 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        pattern_reg <= pattern_next;
        display_reg <= display_next;
    end

    assign bit_valid      = busy_reg;
    assign serial_bit     = pattern_reg[0];
    assign target_display = display_reg;
    assign latch_now      = (cnt_reg == LAST_BIT);

    `SSC_ASSERT(a_load_starts, load |=> (bit_valid && cnt_reg == '0), "load did not restart bits")
    `SSC_ASSERT(a_bit_advance, (take && !latch_now && !load) |=> (bit_valid && cnt_reg == CNT_W'($past(cnt_reg) + 1'b1)), "bit counter did not advance")
    `SSC_ASSERT(a_last_ends, (take && latch_now && !load) |=> !bit_valid, "shifter kept running after last bit")
    `SSC_ASSERT_ALWAYS(a_no_load_busy, (load && busy_reg) |-> (take && latch_now), "load overwrote a pattern in flight")

endmodule

// File: hdl/sixteen_segment_char_serializer_unit.sv
// top level of the sixteen-segment serializer: holding register, encoder, shifter
// depends on ssc_pkg, ssc_encoder, ssc_shifter and the assertion macro header
//
//   channel  | valid      | stall      | payload
//   ---------+------------+------------+-----------------------------------------
//   item     | item_valid | item_stall | cmd, display_select, payload
//   bit      | bit_valid  | bit_stall  | target_display, serial_bit, latch_now
//
// each item yields 16 bit transactions, one per cycle unless bit_stall holds
// them back; the shifter's bit counter sets that figure of 16 transactions
// a holding register takes the next item while the shifter still runs, and the
// item moves over (through the font encoder) in the cycle the last bit is taken
// an item with the undefined command is dropped from the holding register unloaded
// rst_n clears all control state asynchronously; bit_stall freezes the shifter
`include "sixteen_segment_char_serializer_unit_defines.svh"

module sixteen_segment_char_serializer_unit
    import ssc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  logic [1:0]       cmd,
    input  logic             display_select,
    input  logic [SEG_W-1:0] payload,
    output logic             bit_valid,
    input  logic             bit_stall,
    output logic             target_display,
    output logic             serial_bit,
    output logic             latch_now
);

    logic             hold_valid_reg, hold_valid_next;
    logic [1:0]       hold_cmd_reg;
    logic             hold_sel_reg;
    logic [SEG_W-1:0] hold_payload_reg;
    seg_t             enc_pattern;
    logic             enc_emit;
    logic             shift_ready;
    logic             load;
    logic             hold_free;
    logic             accept;
    load_t            load_data;

    // font lookup on the held transaction
    ssc_encoder u_encoder (
        .cmd     (hold_cmd_reg),
        .payload (hold_payload_reg),
        .pattern (enc_pattern),
        .emit    (enc_emit)
    );

    // hand-off: undefined commands drop, others wait for the shifter
    assign load      = hold_valid_reg && enc_emit && shift_ready;
    assign hold_free = !hold_valid_reg || !enc_emit || shift_ready;
    assign item_stall = !hold_free;
    assign accept    = item_valid && hold_free;

    assign load_data.pattern = enc_pattern;
    assign load_data.display = hold_sel_reg;

    always_comb
    begin
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (hold_free)
        begin
            hold_valid_next = 1'b0;
        end
        else
        begin
            hold_valid_next = hold_valid_reg;
        end
    end

    // holding register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    // holding register payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_cmd_reg     <= cmd;
            hold_sel_reg     <= display_select;
            hold_payload_reg <= payload;
        end
    end

    ssc_shifter u_shifter (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (load),
        .load_data      (load_data),
        .ready          (shift_ready),
        .bit_valid      (bit_valid),
        .bit_stall      (bit_stall),
        .target_display (target_display),
        .serial_bit     (serial_bit),
        .latch_now      (latch_now)
    );

    `SSC_ASSERT(a_drop_no_load, (hold_valid_reg && hold_cmd_reg == CMD_NONE) |-> (!load && !item_stall), "undefined command was loaded or blocked input")
    `SSC_ASSERT(a_stall_keeps, (hold_valid_reg && item_stall) |=> (hold_valid_reg && $stable(hold_payload_reg)), "held transaction lost while stalled")

endmodule

// File: tb/tb_sixteen_segment_char_serializer_unit.sv
// self-checking testbench for the sixteen-segment serializer top level
// predicts the 16 bit transactions of every accepted item with a defined command and checks them in order
// depends on ssc_pkg and sixteen_segment_char_serializer_unit
module tb_sixteen_segment_char_serializer_unit;
    import ssc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int REPORT_MAX   = 10;
    localparam int HOLD_CYCLES  = 300;

    // segment glyphs, kept apart from the design's own tables
    localparam logic [15:0] GLYPH_DIGITS [10] = '{
        16'hFF09, 16'h3000, 16'hEEC0, 16'hFCC0, 16'h31C0,
        16'hCD84, 16'hDFC0, 16'hF000, 16'hFFC0, 16'hFDC0
    };
    localparam logic [15:0] GLYPH_LETTERS [26] = '{
        16'hF3C0, 16'hFC52, 16'hCF00, 16'hFC12, 16'hCFC0, 16'hC380, 16'hDF40, 16'h33C0,
        16'hCC12, 16'h3E00, 16'h038C, 16'h0F00, 16'h3328, 16'h3324, 16'hFF00, 16'hE3C0,
        16'hFF04, 16'hE3C4, 16'hDDC0, 16'hC012, 16'h3F00, 16'h0F09, 16'h3305, 16'h002D,
        16'h002A, 16'hCC09
    };
    // blank, underbar, hyphen, backslash, bar, slash, plus, star
    localparam logic [15:0] GLYPH_SYMBOLS [8] = '{
        16'h0000, 16'h0C00, 16'h00C0, 16'h0024, 16'h0012, 16'h0009, 16'h00D2, 16'h00FF
    };
    // character codes that map onto the symbol glyphs, same order
    localparam logic [7:0] SYMBOL_CHARS [8] = '{
        8'h20, 8'h5F, 8'h2D, 8'h5C, 8'h7C, 8'h2F, 8'h2B, 8'h2A
    };

    typedef struct packed {
        logic display;
        logic data;
        logic last;
    } seg_bit_t;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_stall;
    logic [1:0]       cmd;
    logic             display_select;
    logic [SEG_W-1:0] payload;
    logic             bit_valid;
    logic             bit_stall;
    logic             target_display;
    logic             serial_bit;
    logic             latch_now;

    seg_bit_t expected_bits [$];
    int       mismatch_count;
    int       bits_checked;
    int       items_by_cmd [4];
    int       cycle_count;
    bit       sender_gaps;
    bit       receiver_gaps;
    int       hold_request;

    sixteen_segment_char_serializer_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .cmd            (cmd),
        .display_select (display_select),
        .payload        (payload),
        .bit_valid      (bit_valid),
        .bit_stall      (bit_stall),
        .target_display (target_display),
        .serial_bit     (serial_bit),
        .latch_now      (latch_now)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // segment pattern that one item should shift out
    function automatic seg_t segment_pattern(logic [1:0] op, logic [15:0] value);
        logic [7:0] code;
        seg_t       pattern;
        code    = value[7:0];
        pattern = '0;
        case (op)
            CMD_ASCII:
            begin
                // fold lower case onto upper case
                if (code >= 8'h61 && code <= 8'h7A)
                    code = code - 8'h20;
                if (code >= 8'h41 && code <= 8'h5A)
                    pattern = GLYPH_LETTERS[code - 8'h41];
                else if (code >= 8'h30 && code <= 8'h39)
                    pattern = GLYPH_DIGITS[code - 8'h30];
                else
                    for (int i = 0; i < 8; i++)
                        if (code == SYMBOL_CHARS[i])
                            pattern = GLYPH_SYMBOLS[i];
            end
            CMD_RAW:
                pattern = value;
            CMD_SYMBOL:
                if (value < 16'd8)
                    pattern = GLYPH_SYMBOLS[value[2:0]];
            default:
                pattern = '0;
        endcase
        return pattern;
    endfunction

    // cycle counter and timeout
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d bit transactions outstanding",
                     cycle_count, expected_bits.size());
            $display("tb_sixteen_segment_char_serializer_unit: FAIL");
            $finish;
        end
    end

    // item side: every accepted transaction with a defined command expands into its 16 expected bits
    always @(posedge clk)
    begin
        seg_t     pattern;
        seg_bit_t entry;
        if (rst_n && item_valid && !item_stall)
        begin
            items_by_cmd[cmd] = items_by_cmd[cmd] + 1;
            if (cmd != CMD_NONE)
            begin
                pattern = segment_pattern(cmd, payload);
                for (int k = 0; k < SEG_W; k++)
                begin
                    entry.display = display_select;
                    entry.data    = pattern[k];
                    entry.last    = (k == SEG_W - 1);
                    expected_bits.push_back(entry);
                end
            end
        end
    end

    // bit side: compare each accepted transaction with the oldest expectation
    always @(posedge clk)
    begin
        seg_bit_t want;
        if (rst_n && bit_valid && !bit_stall)
        begin
            if (expected_bits.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected bit transaction: display=%0b bit=%0b latch=%0b",
                             target_display, serial_bit, latch_now);
            end
            else
            begin
                want = expected_bits.pop_front();
                bits_checked = bits_checked + 1;
                if (want.display !== target_display || want.data !== serial_bit ||
                    want.last !== latch_now)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= REPORT_MAX)
                        $display("mismatch at bit %0d: expected display=%0b bit=%0b latch=%0b, %s",
                                 bits_checked, want.display, want.data, want.last,
                                 $sformatf("got display=%0b bit=%0b latch=%0b",
                                           target_display, serial_bit, latch_now));
                end
            end
        end
    end

    // receiver stall: random bursts, plus a long hold-off when requested
    initial
    begin
        int burst_left;
        int hold_left;
        bit_stall  = 1'b0;
        burst_left = 0;
        hold_left  = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                bit_stall <= 1'b1;
            end
            else if (burst_left > 0)
            begin
                burst_left = burst_left - 1;
                bit_stall <= 1'b1;
            end
            else if (receiver_gaps && $urandom_range(0, 5) == 0)
            begin
                burst_left = $urandom_range(1, 6) - 1;
                bit_stall <= 1'b1;
            end
            else
                bit_stall <= 1'b0;
        end
    end

    // offer one item and wait until it is taken
    task automatic send_item(cmd_t op, logic sel, logic [15:0] value);
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        item_valid     <= 1'b1;
        cmd            <= op;
        display_select <= sel;
        payload        <= value;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // random character: mostly font entries, some arbitrary codes
    function automatic logic [15:0] random_char();
        logic [7:0] code;
        int         pick;
        pick = $urandom_range(0, 9);
        if (pick <= 3)
            code = 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? 8'h61 : 8'h41);
        else if (pick <= 5)
            code = 8'h30 + 8'($urandom_range(0, 9));
        else if (pick <= 7)
            code = SYMBOL_CHARS[$urandom_range(0, 7)];
        else
            code = 8'($urandom_range(0, 255));
        // the high byte is ignored but should still toggle
        return {8'($urandom_range(0, 255)), code};
    endfunction

    // font corners, raw extremes, symbol range edges and the undefined command
    task automatic test_directed();
        send_item(CMD_ASCII, 1'b0, 16'h0041);
        send_item(CMD_ASCII, 1'b1, 16'h007A);
        send_item(CMD_ASCII, 1'b0, 16'h0030);
        send_item(CMD_ASCII, 1'b1, 16'h0039);
        for (int i = 0; i < 8; i++)
            send_item(CMD_ASCII, i[0], {8'h00, SYMBOL_CHARS[i]});
        // unknown characters, two with a high byte that must be ignored
        send_item(CMD_ASCII, 1'b0, 16'hFF80);
        send_item(CMD_ASCII, 1'b1, 16'h0040);
        send_item(CMD_ASCII, 1'b0, 16'hFF00);
        send_item(CMD_RAW, 1'b1, 16'h0000);
        send_item(CMD_RAW, 1'b0, 16'hFFFF);
        send_item(CMD_RAW, 1'b1, 16'hA5C3);
        send_item(CMD_SYMBOL, 1'b0, 16'h0000);
        send_item(CMD_SYMBOL, 1'b1, 16'h0007);
        // special index out of range
        send_item(CMD_SYMBOL, 1'b0, 16'h0008);
        send_item(CMD_SYMBOL, 1'b1, 16'hFFFF);
        send_item(CMD_NONE, 1'b0, 16'h1234);
    endtask

    // random mix of commands with idling on both sides
    task automatic test_random(int count);
        int   produced;
        int   pick;
        cmd_t op;
        logic [15:0] value;
        produced = 0;
        while (produced < count)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 9)
            begin
                op    = CMD_ASCII;
                value = random_char();
            end
            else if (pick < 14)
            begin
                op    = CMD_RAW;
                value = 16'($urandom_range(0, 65535));
            end
            else if (pick < 18)
            begin
                op    = CMD_SYMBOL;
                value = $urandom_range(0, 3) != 0 ? 16'($urandom_range(0, 7))
                                                  : 16'($urandom_range(0, 65535));
            end
            else
            begin
                op    = CMD_NONE;
                value = 16'($urandom_range(0, 65535));
            end
            send_item(op, 1'($urandom_range(0, 1)), value);
            if (op != CMD_NONE)
                produced = produced + 1;
        end
    endtask

    // receiver holds off long while the sender keeps offering items
    task automatic test_backpressure(int count);
        sender_gaps  = 1'b0;
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < count; i++)
            send_item(CMD_RAW, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
        sender_gaps = 1'b1;
    endtask

    // back-to-back traffic with no idling at all
    task automatic test_full_rate(int count);
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        for (int i = 0; i < count; i++)
            send_item(i % 3 == 0 ? CMD_RAW : CMD_ASCII, 1'($urandom_range(0, 1)),
                      i % 3 == 0 ? 16'($urandom_range(0, 65535)) : random_char());
    endtask

    // main sequence
    initial
    begin
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        cmd            = CMD_ASCII;
        display_select = 1'b0;
        payload        = '0;
        mismatch_count = 0;
        bits_checked   = 0;
        cycle_count    = 0;
        hold_request   = 0;
        sender_gaps    = 1'b1;
        receiver_gaps  = 1'b1;
        items_by_cmd   = '{0, 0, 0, 0};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(250);
        test_backpressure(20);
        test_full_rate(40);

        item_valid <= 1'b0;
        while (expected_bits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("items taken: %0d ascii, %0d raw, %0d symbol, %0d undefined",
                 items_by_cmd[CMD_ASCII], items_by_cmd[CMD_RAW],
                 items_by_cmd[CMD_SYMBOL], items_by_cmd[CMD_NONE]);
        $display("bit transactions checked: %0d, mismatches: %0d",
                 bits_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("tb_sixteen_segment_char_serializer_unit: PASS");
        else
            $display("tb_sixteen_segment_char_serializer_unit: FAIL");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/ssc_pkg.sv
hdl/ssc_encoder.sv
hdl/ssc_shifter.sv
hdl/sixteen_segment_char_serializer_unit.sv
tb/tb_sixteen_segment_char_serializer_unit.sv
